/* rtl/core/esd_pkg.sv */
`timescale 1ns / 1ps

package esd_pkg;

    // Day split: secs / 86400 = (secs >> 7) / 675, reciprocal of 675 at 2^34
    localparam logic [24:0] DAY_RECIP  = 25'd25451658;
    localparam int          DAY_SHIFT  = 34;
    localparam logic [16:0] SECS_DAY   = 17'd86400;

    // Hour split: tod / 3600 = (tod >> 4) / 225, exact below 7037
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;

    // Minute split: r / 60 = (r >> 2) / 15, exact below 1489
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam logic [5:0]  SECS_MIN   = 6'd60;

    // Four-year cycles from 1901, exact below 94519
    localparam logic [15:0] CYC_RECIP  = 16'd45934;
    localparam logic [10:0] CYC_DAYS   = 11'd1461;
    localparam logic [8:0]  COMMON_YEAR_LEN = 9'd365;
    localparam logic [10:0] BASE_YEAR  = 11'd1900;

    // Weekday: d / 7 by reciprocal at 2^19, exact below 104857
    localparam logic [16:0] WEEK_RECIP = 17'd74899;
    localparam logic [2:0]  WEEK_DAYS  = 3'd7;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] tod;
    } day_beat_t;

    // Day of year on which a month opens, counted from 0
    function automatic logic [8:0] month_first(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        unique case (mon)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd3)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

/* rtl/core/esd_daydiv.sv */
`timescale 1ns / 1ps

module esd_daydiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        secs,
    output logic               out_valid,
    output esd_pkg::day_beat_t out_beat
);

    logic [2:0]  valid_reg;
    logic [49:0] prod_reg;
    logic [49:0] prod_next;
    logic [31:0] secs1_reg;
    logic [31:0] secs2_reg;
    logic [15:0] quot_reg;
    logic [31:0] qm_reg;
    logic [32:0] qm_next;
    esd_pkg::day_beat_t beat_reg;
    esd_pkg::day_beat_t beat_next;
    logic [17:0] rem;

    // Estimate may fall one short; fix it after the back-multiply
    always_comb
    begin
        prod_next = 50'(secs[31:7]) * 50'(esd_pkg::DAY_RECIP);
        qm_next   = 33'(prod_reg[49:esd_pkg::DAY_SHIFT]) * 33'(esd_pkg::SECS_DAY);
        rem       = 18'(secs2_reg - qm_reg);
        if (rem >= 18'(esd_pkg::SECS_DAY))
        begin
            beat_next.days = quot_reg + 16'd1;
            beat_next.tod  = 17'(rem - 18'(esd_pkg::SECS_DAY));
        end
        else
        begin
            beat_next.days = quot_reg;
            beat_next.tod  = rem[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        secs1_reg <= secs;
        quot_reg  <= prod_reg[49:esd_pkg::DAY_SHIFT];
        qm_reg    <= qm_next[31:0];
        secs2_reg <= secs1_reg;
        beat_reg  <= beat_next;
    end

    assign out_valid = valid_reg[2];
    assign out_beat  = beat_reg;

endmodule

/* rtl/core/esd_tod.sv */
`timescale 1ns / 1ps

module esd_tod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [16:0] tod,
    output logic        out_valid,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [4:0]  valid_reg;
    logic [25:0] hp_reg;
    logic [25:0] hp_next;
    logic [16:0] tod1_reg;
    logic [16:0] tod2_reg;
    logic [4:0]  hour2_reg;
    logic [4:0]  hour3_reg;
    logic [4:0]  hour4_reg;
    logic [4:0]  hour5_reg;
    logic [16:0] hm_reg;
    logic [16:0] hm_next;
    logic [11:0] remh3_reg;
    logic [11:0] remh4_reg;
    logic [11:0] remh_next;
    logic [20:0] mp_reg;
    logic [20:0] mp_next;
    logic [5:0]  min4_reg;
    logic [5:0]  min5_reg;
    logic [11:0] mm_reg;
    logic [11:0] mm_next;
    logic [5:0]  sec_reg;
    logic [5:0]  sec_next;

    always_comb
    begin
        hp_next   = 26'(tod[16:4]) * 26'(esd_pkg::HOUR_RECIP);
        hm_next   = 17'(hp_reg[24:20]) * 17'(esd_pkg::SECS_HOUR);
        remh_next = 12'(tod2_reg - hm_reg);
        mp_next   = 21'(remh_next[11:2]) * 21'(esd_pkg::MIN_RECIP);
        mm_next   = 12'(mp_reg[19:14]) * 12'(esd_pkg::SECS_MIN);
        sec_next  = 6'(remh4_reg - mm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        hp_reg    <= hp_next;
        tod1_reg  <= tod;
        hour2_reg <= hp_reg[24:20];
        hm_reg    <= hm_next;
        tod2_reg  <= tod1_reg;
        hour3_reg <= hour2_reg;
        remh3_reg <= remh_next;
        mp_reg    <= mp_next;
        hour4_reg <= hour3_reg;
        min4_reg  <= mp_reg[19:14];
        mm_reg    <= mm_next;
        remh4_reg <= remh3_reg;
        hour5_reg <= hour4_reg;
        min5_reg  <= min4_reg;
        sec_reg   <= sec_next;
    end

    assign out_valid = valid_reg[4];
    assign hour      = hour5_reg;
    assign minute    = min5_reg;
    assign second    = sec_reg;

endmodule

/* rtl/core/esd_cal.sv */
`timescale 1ns / 1ps

module esd_cal (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] days,
    output logic        out_valid,
    output logic [10:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday
);

    logic [4:0]  valid_reg;

    // Stage 1
    logic        first1_reg;
    logic [15:0] days1_reg;
    logic [15:0] e1_reg;
    logic [15:0] d1_1_reg;
    logic [31:0] ep_reg;
    logic [31:0] wp_reg;
    logic        first_next;
    logic [15:0] e_next;
    logic [15:0] d1_next;
    logic [31:0] ep_next;
    logic [32:0] wp_next;

    // Stage 2
    logic        first2_reg;
    logic [8:0]  days2_reg;
    logic [15:0] e2_reg;
    logic [15:0] d1_2_reg;
    logic [5:0]  cyc2_reg;
    logic [15:0] cm_reg;
    logic [15:0] wm_reg;
    logic [15:0] cm_next;
    logic [15:0] wm_next;

    // Stage 3
    logic [10:0] year3_reg;
    logic [8:0]  doy3_reg;
    logic        leap3_reg;
    logic [2:0]  wd3_reg;
    logic [10:0] year_next;
    logic [8:0]  doy_next;
    logic        leap_next;
    logic [2:0]  wd_next;
    logic [10:0] rem;
    logic [1:0]  yr_in;
    logic [10:0] yr_off;

    // Stage 4
    logic [10:0] year4_reg;
    logic [3:0]  mon4_reg;
    logic [8:0]  doy4_reg;
    logic [8:0]  mstart4_reg;
    logic [2:0]  wd4_reg;
    logic [3:0]  mon_next;

    // Stage 5
    logic [10:0] year5_reg;
    logic [3:0]  mon5_reg;
    logic [4:0]  dom5_reg;
    logic [2:0]  wd5_reg;
    logic [8:0]  dom_next;

    always_comb
    begin
        // Stage 1: split off 1900, open the four-year and weekday divides
        first_next = (days < 16'(esd_pkg::COMMON_YEAR_LEN));
        e_next     = first_next ? 16'd0 : days - 16'(esd_pkg::COMMON_YEAR_LEN);
        d1_next    = days + 16'd1;
        ep_next    = 32'(e_next) * 32'(esd_pkg::CYC_RECIP);
        wp_next    = 33'(d1_next) * 33'(esd_pkg::WEEK_RECIP);

        // Stage 2: back-multiply the quotients
        cm_next = 16'(ep_reg[31:26]) * 16'(esd_pkg::CYC_DAYS);
        wm_next = 16'(wp_reg[31:19]) * 16'(esd_pkg::WEEK_DAYS);

        // Stage 3: year within the cycle; the fourth year is the leap one
        rem = 11'(e2_reg - cm_reg);
        priority if (rem >= 11'd1095)
        begin
            yr_in  = 2'd3;
            yr_off = 11'd1095;
        end
        else if (rem >= 11'd730)
        begin
            yr_in  = 2'd2;
            yr_off = 11'd730;
        end
        else if (rem >= 11'd365)
        begin
            yr_in  = 2'd1;
            yr_off = 11'd365;
        end
        else
        begin
            yr_in  = 2'd0;
            yr_off = 11'd0;
        end
        if (first2_reg)
        begin
            year_next = esd_pkg::BASE_YEAR;
            doy_next  = days2_reg;
            leap_next = 1'b0;
        end
        else
        begin
            year_next = esd_pkg::BASE_YEAR + 11'd1 + {3'd0, cyc2_reg, 2'd0} + 11'(yr_in);
            doy_next  = 9'(rem - yr_off);
            leap_next = (yr_in == 2'd3);
        end
        wd_next = 3'(d1_2_reg - wm_reg);

        // Stage 4: count month openings already passed
        mon_next = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (doy3_reg >= esd_pkg::month_first(4'(i), leap3_reg))
            begin
                mon_next = mon_next + 4'd1;
            end
        end

        // Stage 5
        dom_next = doy4_reg - mstart4_reg + 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg  <= first_next;
        days1_reg   <= days;
        e1_reg      <= e_next;
        d1_1_reg    <= d1_next;
        ep_reg      <= ep_next;
        wp_reg      <= wp_next[31:0];

        first2_reg  <= first1_reg;
        days2_reg   <= days1_reg[8:0];
        e2_reg      <= e1_reg;
        d1_2_reg    <= d1_1_reg;
        cyc2_reg    <= ep_reg[31:26];
        cm_reg      <= cm_next;
        wm_reg      <= wm_next;

        year3_reg   <= year_next;
        doy3_reg    <= doy_next;
        leap3_reg   <= leap_next;
        wd3_reg     <= wd_next;

        year4_reg   <= year3_reg;
        mon4_reg    <= mon_next;
        doy4_reg    <= doy3_reg;
        mstart4_reg <= esd_pkg::month_first(mon_next, leap3_reg);
        wd4_reg     <= wd3_reg;

        year5_reg   <= year4_reg;
        mon5_reg    <= mon4_reg;
        dom5_reg    <= dom_next[4:0];
        wd5_reg     <= wd4_reg;
    end

    assign out_valid    = valid_reg[4];
    assign year         = year5_reg;
    assign month        = mon5_reg;
    assign day_of_month = dom5_reg;
    assign weekday      = wd5_reg;

endmodule

/* rtl/core/epoch1900_seconds_to_date.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ---------------------------------------------
// request   in         start & !busy       seconds_since_1900[31:0]
// result    out        done (one cycle)    year, month, day_of_month, hour, minute,
//                                          second, weekday
//
// A beat may be accepted on every cycle; busy stays low, throughput is one beat a cycle.
// Each beat passes the multiply-by-reciprocal chain: capture, three day-divide
// stages, then five stages in each of the time-of-day and calendar branches.
// Reset clears only the valid bits; payload registers start unknown and are never seen.
// The receiver cannot stall, so no beat is ever held back; done simply follows start.

module epoch1900_seconds_to_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] seconds_since_1900,
    output logic        done,
    output logic [10:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);

    logic               in_valid_reg;
    logic [31:0]        secs_reg;
    logic               day_valid;
    esd_pkg::day_beat_t day_beat;
    logic               tod_valid;
    logic               cal_valid;

    // The pipeline never backs up, so accept a beat on every cycle
    assign busy = 1'b0;

    // Capture the request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= seconds_since_1900;
    end

    // Split seconds into whole days and second of day
    esd_daydiv u_daydiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .secs      (secs_reg),
        .out_valid (day_valid),
        .out_beat  (day_beat)
    );

    // Hour, minute, second from the second of day
    esd_tod u_tod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day_valid),
        .tod       (day_beat.tod),
        .out_valid (tod_valid),
        .hour      (hour),
        .minute    (minute),
        .second    (second)
    );

    // Year, month, day and weekday from the day count; same depth as the time branch
    esd_cal u_cal (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (day_valid),
        .days         (day_beat.days),
        .out_valid    (cal_valid),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .weekday      (weekday)
    );

    assign done = cal_valid;

    // Both branches must deliver the same beat together
    a_branch_align: assert property (@(posedge clk) disable iff (!rst_n)
        tod_valid == cal_valid)
        else $error("time and calendar branches out of step");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
                 && (weekday < 3'd7) && (year >= 11'd1900) && (year <= 11'd2036))
        else $error("calendar date out of range");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        day_valid |-> ##5 done)
        else $error("result beat lost in the pipeline");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Calendar arithmetic used by the date predictor
    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned MINUTE_SECONDS = 60;
    localparam int unsigned EPOCH_YEAR     = 1900;
    localparam int unsigned WEEK_LENGTH    = 7;

    // Cycles to let pass after the last result before the verdict
    localparam int          DRAIN_CYCLES   = 12;

    // One predicted date, tagged with the stamp it came from for reporting
    typedef struct {
        logic [31:0] stamp;
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } cal_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] seconds_since_1900 = '0;
    logic        busy;
    logic        done;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    // Dates still owed by the block, oldest first
    cal_date_t pending_dates[$];
    int        mismatch_count = 0;

    epoch1900_seconds_to_date dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .seconds_since_1900 (seconds_since_1900),
        .done               (done),
        .year               (year),
        .month              (month),
        .day_of_month       (day_of_month),
        .hour               (hour),
        .minute             (minute),
        .second             (second),
        .weekday            (weekday)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar helpers
    // ------------------------------------------------------------------

    // Gregorian rule: every fourth year, except centuries not divisible by 400
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned year_length(input int unsigned yr);
        return is_leap(yr) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
        case (mon)
            2:            return is_leap(yr) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Seconds for the first day of a month, shifted by a day offset, plus a time of day
    function automatic longint stamp_of(input int unsigned yr, input int unsigned mon,
                                        input int day_off, input int unsigned tod);
        longint days;
        days = day_off;
        for (int unsigned y = EPOCH_YEAR; y < yr; y++)
        begin
            days += year_length(y);
        end
        for (int unsigned m = 1; m < mon; m++)
        begin
            days += month_length(yr, m);
        end
        return days * DAY_SECONDS + tod;
    endfunction

    // Walk whole years from the epoch, then whole months
    function automatic cal_date_t predict_date(input logic [31:0] stamp);
        cal_date_t   d;
        int unsigned secs;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        secs = stamp;
        days = secs / DAY_SECONDS;
        tod  = secs % DAY_SECONDS;
        // The epoch day fell on a Monday
        d.weekday = 3'((days + 1) % WEEK_LENGTH);
        yr = EPOCH_YEAR;
        while (days >= year_length(yr))
        begin
            days -= year_length(yr);
            yr++;
        end
        mon = 1;
        while ((mon < 12) && (days >= month_length(yr, mon)))
        begin
            days -= month_length(yr, mon);
            mon++;
        end
        d.stamp        = stamp;
        d.year         = 11'(yr);
        d.month        = 4'(mon);
        d.day_of_month = 5'(days + 1);
        d.hour         = 5'(tod / HOUR_SECONDS);
        d.minute       = 6'((tod % HOUR_SECONDS) / MINUTE_SECONDS);
        d.second       = 6'(tod % MINUTE_SECONDS);
        return d;
    endfunction

    // Mostly back-to-back, some short pauses, an occasional long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [10:0] got,
                               input logic [10:0] want, input logic [31:0] stamp);
        if (got !== want)
            report_mismatch($sformatf("stamp %0d %s got %0d want %0d", stamp, name, got, want));
    endtask

    // Take each result on the edge that closes its done cycle and hold it
    // against the oldest outstanding prediction. The block cannot be held
    // off, so every done cycle is one result.
    always @(posedge clk)
    begin : result_check
        cal_date_t want;
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                report_mismatch($sformatf("result %0d-%0d-%0d with no beat outstanding",
                                          year, month, day_of_month));
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("year",         year,         want.year,         want.stamp);
                check_field("month",        month,        want.month,        want.stamp);
                check_field("day_of_month", day_of_month, want.day_of_month, want.stamp);
                check_field("hour",         hour,         want.hour,         want.stamp);
                check_field("minute",       minute,       want.minute,       want.stamp);
                check_field("second",       second,       want.second,       want.stamp);
                check_field("weekday",      weekday,      want.weekday,      want.stamp);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one stamp and hold it until the block takes it. On acceptance,
    // record the predicted date. With a gap, drop start and put junk on the
    // data port for the pause; with no gap, leave start high so the next
    // call carries straight on without touching it twice in one step.
    task automatic send_stamp(input logic [31:0] stamp, input int gap);
        start              <= 1'b1;
        seconds_since_1900 <= stamp;
        do
            @(posedge clk);
        while (busy);
        pending_dates.push_back(predict_date(stamp));
        if (gap > 0)
        begin
            start              <= 1'b0;
            seconds_since_1900 <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Field extremes, leap-year rule at 1900, 1904 and 2000, year and
    // month rollovers, the top of the input range and a full week.
    task automatic test_directed();
        send_stamp(32'h0000_0000, 0);
        send_stamp(32'hFFFF_FFFF, pick_gap());
        send_stamp(32'(DAY_SECONDS - 1), 0);
        send_stamp(32'(DAY_SECONDS), 1);
        // 1900 is a century year, so February has 28 days
        send_stamp(32'(stamp_of(1900, 3, -1, DAY_SECONDS - 1)), 0);
        send_stamp(32'(stamp_of(1900, 3, 0, 0)), 2);
        send_stamp(32'(stamp_of(1901, 1, -1, DAY_SECONDS - 1)), 0);
        send_stamp(32'(stamp_of(1901, 1, 0, 0)), 0);
        send_stamp(32'(stamp_of(1904, 3, -1, 43200)), 3);
        send_stamp(32'(stamp_of(1904, 3, 0, 1)), 0);
        // 2000 is divisible by 400, so it is a leap year
        send_stamp(32'(stamp_of(2000, 3, -1, 45296)), 0);
        send_stamp(32'(stamp_of(2000, 3, 0, 0)), 1);
        send_stamp(32'(stamp_of(2001, 1, -1, DAY_SECONDS - 1)), 0);
        send_stamp(32'(stamp_of(2001, 1, 0, 0)), 0);
        send_stamp(32'(stamp_of(2000, 1, -1, DAY_SECONDS - 1)), 5);
        send_stamp(32'hFFFF_FFFE, 0);
        for (int k = 0; k < 7; k++)
        begin
            send_stamp(32'(stamp_of(2024, 1, k, 3661)), pick_gap());
        end
    endtask

    // Full-range stamps with random pauses: every input bit toggles
    task automatic test_random_range(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_stamp($urandom, pick_gap());
        end
    endtask

    // Stamps clustered on month, year and day boundaries
    task automatic test_boundaries(input int count);
        int unsigned yr;
        int unsigned mon;
        int          off;
        int unsigned tod;
        longint      stamp;
        for (int i = 0; i < count; i++)
        begin
            yr  = $urandom_range(EPOCH_YEAR, 2036);
            mon = $urandom_range(1, 12);
            off = $urandom_range(0, 1) ? -1 : 0;
            tod = $urandom_range(0, 1) ? $urandom_range(0, 2)
                                       : $urandom_range(DAY_SECONDS - 3, DAY_SECONDS - 1);
            // Nothing lies before the epoch
            if ((yr == EPOCH_YEAR) && (mon == 1))
                off = 0;
            stamp = stamp_of(yr, mon, off, tod);
            // Fold anything past the top of the range back to its last few days
            if (stamp > 64'hFFFF_FFFF)
                stamp = 64'hFFFF_FFFF - $urandom_range(0, 3 * DAY_SECONDS);
            send_stamp(32'(stamp), pick_gap());
        end
    endtask

    // One beat on every cycle, start held high throughout
    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_stamp($urandom, 0);
        end
    endtask

    // Long pauses so the pipeline drains between beats
    task automatic test_long_gaps(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_stamp($urandom, $urandom_range(10, 40));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence and verdict
    // ------------------------------------------------------------------

    initial
    begin
        // Hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_range(1000);
        test_boundaries(500);
        test_back_to_back(300);
        test_long_gaps(50);

        // Drop start once the last beat is in and let the results drain
        start <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Stop a run that hangs, well beyond the slowest correct one
    initial
    begin
        #2_000_000;
        $display("[%0t] timeout with %0d results outstanding", $realtime, pending_dates.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/esd_pkg.sv
rtl/core/esd_daydiv.sv
rtl/core/esd_tod.sv
rtl/core/esd_cal.sv
rtl/core/epoch1900_seconds_to_date.sv
tb/sv/tb.sv
